// ----- rtl/stpm_pkg.sv -----
// ----------------------------------------------------------------------------
// stpm_pkg: shared types and helpers for the subset top-two pair max core
// Widths, candidate ordering, and controller/datapath command and status.
// ----------------------------------------------------------------------------
package stpm_pkg;

	localparam int LOG_MAX = 10;
	localparam int DEPTH   = 1 << LOG_MAX;
	localparam int IDX_W   = LOG_MAX;
	localparam int CNT_W   = LOG_MAX + 1;
	localparam int VAL_W   = 32;
	localparam int SUM_W   = VAL_W + 1;
	localparam int LOG_W   = 4;
	localparam int BIT_W   = (LOG_MAX > 1) ? $clog2(LOG_MAX) : 1;

	localparam logic [LOG_W-1:0] LOG_RESET = LOG_W'(10);

	typedef struct packed {
		logic [VAL_W-1:0] val;
		logic [IDX_W-1:0] idx;
	} cand_t;

	typedef struct packed {
		cand_t top;
		cand_t sec;
	} entry_t;

	typedef struct packed {
		cand_t top;
		cand_t sec;
		logic  sec_vld;
	} pair_t;

	typedef struct packed {
		logic             load_first;
		logic             load_item;
		logic             rd_en;
		logic [BIT_W-1:0] bit_sel;
		logic             finish;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic out_free;
	} sts_t;

	// order by value, then by index
	function automatic logic cand_gt(cand_t a, cand_t b);
		if (a.val != b.val) begin
			return a.val > b.val;
		end
		return a.idx > b.idx;
	endfunction

	// keeps the max and the max whose index differs from it
	function automatic pair_t pair_merge(pair_t p, cand_t c);
		pair_t r;
		r = p;
		if (cand_gt(c, p.top)) begin
			if (c.idx != p.top.idx) begin
				r.sec     = p.top;
				r.sec_vld = 1'b1;
			end
			r.top = c;
		end else if (c.idx != p.top.idx && (!p.sec_vld || cand_gt(c, p.sec))) begin
			r.sec     = c;
			r.sec_vld = 1'b1;
		end
		return r;
	endfunction

endpackage

// ----- rtl/stpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// stpm_ctrl: sequencer for the subset top-two pair max core
// Accepts an item, walks the index bits issuing pair reads, then writes back.
// ----------------------------------------------------------------------------
module stpm_ctrl
	import stpm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic value_valid,
	output logic value_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]       state_q;
	logic [1:0]       state_d;
	logic [BIT_W-1:0] bit_q;
	logic [BIT_W-1:0] bit_d;
	logic             accept;

	assign value_stall = (state_q != ST_IDLE);
	assign accept      = value_valid && (state_q == ST_IDLE);

	always_comb begin
		state_d         = state_q;
		bit_d           = bit_q;
		cmd             = '0;
		cmd.bit_sel     = bit_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (sts.count_zero) begin
						cmd.load_first = 1'b1;
					end else begin
						cmd.load_item = 1'b1;
						bit_d         = '0;
						state_d       = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (bit_q == BIT_W'(LOG_MAX - 1)) begin
					state_d = ST_DRAIN;
				end else begin
					bit_d = bit_q + BIT_W'(1);
				end
			end
			ST_DRAIN: begin
				// last read lands in the accumulator this cycle
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			bit_q   <= bit_d;
		end
	end

endmodule

// ----- rtl/stpm_dpath.sv -----
// ----------------------------------------------------------------------------
// stpm_dpath: datapath for the subset top-two pair max core
// Pair store, top-two accumulator, running best, run counter, output register.
// ----------------------------------------------------------------------------
module stpm_dpath
	import stpm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              log_size_we,
	input  logic [LOG_W-1:0]  log_size_wdata,
	input  logic [VAL_W-1:0]  value,
	input  cmd_t              cmd,
	output sts_t              sts,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [SUM_W-1:0]  best_sum,
	output logic [IDX_W-1:0]  mask_index,
	output logic              last_of_run
);

	logic [LOG_W-1:0] log_q;
	logic [VAL_W-1:0] first_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] best_q;
	logic [IDX_W-1:0] cur_idx_q;
	pair_t            acc_q;

	entry_t           mem [DEPTH];
	entry_t           rd_s1;
	logic             rd_hit_s1;
	logic             rd_zero_s1;

	logic             result_valid_q;
	logic [SUM_W-1:0] best_sum_q;
	logic [IDX_W-1:0] mask_index_q;
	logic             last_q;

	logic [LOG_W-1:0] lg;
	logic [CNT_W-1:0] last_cnt;
	logic             is_last;
	logic [IDX_W-1:0] rd_addr;
	pair_t            acc_init;
	pair_t            acc_rd;
	cand_t            c_top;
	cand_t            c_sec;
	logic [SUM_W-1:0] pair_sum;
	logic [SUM_W-1:0] new_best;

	// out-of-range sizes clamp to [1, LOG_MAX]
	always_comb begin
		priority if (log_q == '0) begin
			lg = LOG_W'(1);
		end else if (log_q > LOG_W'(LOG_MAX)) begin
			lg = LOG_W'(LOG_MAX);
		end else begin
			lg = log_q;
		end
	end

	assign last_cnt = (CNT_W'(1) << lg) - CNT_W'(1);
	assign is_last  = (count_q >= last_cnt);
	assign rd_addr  = cur_idx_q ^ (IDX_W'(1) << cmd.bit_sel);

	always_comb begin
		pair_t base;
		base.top     = '{val: first_q, idx: '0};
		base.sec     = '0;
		base.sec_vld = 1'b0;
		acc_init     = pair_merge(base, '{val: value, idx: count_q[IDX_W-1:0]});
	end

	// mask zero has no stored entry: both its pairs are (0, 0)
	assign c_top  = rd_zero_s1 ? cand_t'('0) : rd_s1.top;
	assign c_sec  = rd_zero_s1 ? cand_t'('0) : rd_s1.sec;
	assign acc_rd = pair_merge(pair_merge(acc_q, c_top), c_sec);

	assign pair_sum = {1'b0, acc_q.top.val} + {1'b0, acc_q.sec.val};
	assign new_best = (pair_sum > best_q) ? pair_sum : best_q;

	assign sts.count_zero = (count_q == '0);
	assign sts.out_free   = !result_valid_q || !result_stall;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			mem[cur_idx_q] <= '{top: acc_q.top, sec: acc_q.sec};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_hit_s1  <= 1'b0;
			rd_zero_s1 <= 1'b0;
		end else begin
			rd_hit_s1  <= cmd.rd_en && cur_idx_q[cmd.bit_sel];
			rd_zero_s1 <= (rd_addr == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			cur_idx_q <= count_q[IDX_W-1:0];
			acc_q     <= acc_init;
		end else if (rd_hit_s1) begin
			acc_q <= acc_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_q   <= LOG_RESET;
			first_q <= '0;
			count_q <= '0;
			best_q  <= '0;
		end else begin
			if (log_size_we) begin
				log_q <= log_size_wdata;
			end
			if (cmd.load_first) begin
				first_q <= value;
				count_q <= CNT_W'(1);
			end else if (cmd.finish) begin
				if (is_last) begin
					count_q <= '0;
					best_q  <= '0;
				end else begin
					count_q <= count_q + CNT_W'(1);
					best_q  <= new_best;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			best_sum_q   <= new_best;
			mask_index_q <= cur_idx_q;
			last_q       <= is_last;
		end
	end

	assign result_valid = result_valid_q;
	assign best_sum     = best_sum_q;
	assign mask_index   = mask_index_q;
	assign last_of_run  = last_q;

endmodule

// ----- rtl/subset_top_two_pair_max_core.sv -----
// ----------------------------------------------------------------------------
// subset_top_two_pair_max_core: running max of top-two pair sums over subsets
// Each accepted item is walked through its index bits, one pair-store read per
// bit, and its result is registered once the last read is merged; writeback
// waits while the output register still holds a stalled result. The input
// stalls until then; item 0 of a run is only latched and gives no result.
// Reset: async, clears run counter, running best, first value, log_size = 10.
// ----------------------------------------------------------------------------
module subset_top_two_pair_max_core
	import stpm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              log_size_we,
	input  logic [LOG_W-1:0]  log_size_wdata,
	input  logic              value_valid,
	output logic              value_stall,
	input  logic [VAL_W-1:0]  value,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [SUM_W-1:0]  best_sum,
	output logic [IDX_W-1:0]  mask_index,
	output logic              last_of_run
);

	cmd_t cmd;
	sts_t sts;

	stpm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	stpm_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.log_size_we    (log_size_we),
		.log_size_wdata (log_size_wdata),
		.value          (value),
		.cmd            (cmd),
		.sts            (sts),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.best_sum       (best_sum),
		.mask_index     (mask_index),
		.last_of_run    (last_of_run)
	);

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("writeback while output register still held");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		value_stall |-> !cmd.load_item && !cmd.load_first)
		else $error("item loaded while busy");

	a_rose_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(cmd.finish))
		else $error("result appeared without writeback");

	a_index_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> mask_index != '0)
		else $error("result for index zero");

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for subset_top_two_pair_max_core
// Sends runs of values and predicts each result: the top-two pair per mask,
// the running best pair sum, the index and the end-of-run flag. Covers value
// extremes, ties, run settings 0-5, 9, 10 and 15 (0 and 15 clamp), lowering
// the run length mid run, random idling on both channels, and a long output
// hold-off that backs the core up into its input.
// ----------------------------------------------------------------------------
module tb_top;
	import stpm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned DRAIN_PAD   = 20;
	localparam int unsigned HOLD_LEN    = 300;
	localparam int unsigned CAND_MAX    = 2 + 2 * LOG_MAX;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [IDX_W-1:0] idx;
		logic             last;
	} result_t;

	logic             clk            = 1'b0;
	logic             arst_n         = 1'b0;
	logic             log_size_we    = 1'b0;
	logic [LOG_W-1:0] log_size_wdata = '0;
	logic             value_valid    = 1'b0;
	logic             value_stall;
	logic [VAL_W-1:0] value          = '0;
	logic             result_valid;
	logic             result_stall   = 1'b0;
	logic [SUM_W-1:0] best_sum;
	logic [IDX_W-1:0] mask_index;
	logic             last_of_run;

	// predictor state
	logic [LOG_W-1:0] cur_log = LOG_RESET;
	logic [VAL_W-1:0] seed_val = '0;
	logic [CNT_W-1:0] run_pos = '0;
	logic [SUM_W-1:0] run_best = '0;
	logic [VAL_W-1:0] best_val [DEPTH];
	logic [IDX_W-1:0] best_idx [DEPTH];
	logic [VAL_W-1:0] next_val [DEPTH];
	logic [IDX_W-1:0] next_idx [DEPTH];
	result_t          running_max_q [$];

	int unsigned err_count     = 0;
	int unsigned cycle_count   = 0;
	int unsigned src_idle_pct  = 0;
	int unsigned snk_stall_pct = 0;
	int unsigned hold_reqs     = 0;
	int unsigned hold_taken    = 0;
	int unsigned hold_left     = 0;

	subset_top_two_pair_max_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.log_size_we    (log_size_we),
		.log_size_wdata (log_size_wdata),
		.value_valid    (value_valid),
		.value_stall    (value_stall),
		.value          (value),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.best_sum       (best_sum),
		.mask_index     (mask_index),
		.last_of_run    (last_of_run)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// output stall: random, or a long counted hold-off on request
	always @(negedge clk) begin
		if (hold_reqs != hold_taken) begin
			hold_taken = hold_reqs;
			hold_left  = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < snk_stall_pct);
		end
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (running_max_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result idx %0d sum %0h",
					mask_index, best_sum));
			end else begin
				want = running_max_q.pop_front();
				if (best_sum !== want.sum)
					report_mismatch($sformatf("idx %0d best_sum %0h, want %0h",
						want.idx, best_sum, want.sum));
				if (mask_index !== want.idx)
					report_mismatch($sformatf("mask_index %0d, want %0d",
						mask_index, want.idx));
				if (last_of_run !== want.last)
					report_mismatch($sformatf("idx %0d last_of_run %b, want %b",
						want.idx, last_of_run, want.last));
			end
		end
	end

	// order by value, then by index
	function automatic bit ranks_above(input logic [VAL_W-1:0] av, input logic [IDX_W-1:0] ai,
			input logic [VAL_W-1:0] bv, input logic [IDX_W-1:0] bi);
		if (av != bv)
			return av > bv;
		return ai > bi;
	endfunction

	// update the pair stores for one accepted value and queue its result (item 0 only seeds the run)
	function automatic void fold_value(input logic [VAL_W-1:0] v);
		int unsigned      lg, run_len, k;
		logic [IDX_W-1:0] idx, m;
		logic [VAL_W-1:0] cv [CAND_MAX];
		logic [IDX_W-1:0] ci [CAND_MAX];
		logic [VAL_W-1:0] tv, sv;
		logic [IDX_W-1:0] ti, si;
		bit               have_s, last;
		logic [SUM_W-1:0] pair_sum;
		result_t          res;
		lg = cur_log;
		if (lg < 1)
			lg = 1;
		if (lg > LOG_MAX)
			lg = LOG_MAX;
		run_len = 1 << lg;
		if (run_pos == 0) begin
			seed_val = v;
			run_pos  = 1;
			return;
		end
		idx  = run_pos[IDX_W-1:0];
		last = (run_pos >= run_len - 1);
		cv[0] = seed_val;
		ci[0] = '0;
		cv[1] = v;
		ci[1] = idx;
		k = 2;
		for (int j = 0; j < LOG_MAX; j++) begin
			if (idx[j]) begin
				m = idx ^ (IDX_W'(1) << j);
				if (m == 0) begin
					cv[k] = '0; ci[k] = '0;
					cv[k+1] = '0; ci[k+1] = '0;
				end else begin
					cv[k] = best_val[m]; ci[k] = best_idx[m];
					cv[k+1] = next_val[m]; ci[k+1] = next_idx[m];
				end
				k += 2;
			end
		end
		tv = cv[0];
		ti = ci[0];
		for (int j = 1; j < k; j++) begin
			if (ranks_above(cv[j], ci[j], tv, ti)) begin
				tv = cv[j];
				ti = ci[j];
			end
		end
		sv = '0;
		si = '0;
		have_s = 1'b0;
		for (int j = 0; j < k; j++) begin
			if (ci[j] == ti)
				continue;
			if (!have_s || ranks_above(cv[j], ci[j], sv, si)) begin
				sv = cv[j];
				si = ci[j];
				have_s = 1'b1;
			end
		end
		best_val[idx] = tv;
		best_idx[idx] = ti;
		next_val[idx] = sv;
		next_idx[idx] = si;
		pair_sum = SUM_W'(tv) + SUM_W'(sv);
		if (pair_sum > run_best)
			run_best = pair_sum;
		res = '{run_best, idx, last};
		running_max_q.insert(running_max_q.size(), res);
		if (last) begin
			run_pos  = '0;
			run_best = '0;
		end else begin
			run_pos = run_pos + 1'b1;
		end
	endfunction

	function automatic logic [VAL_W-1:0] rand_value();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return VAL_W'($urandom_range(3));           // ties
			3: return '1 - VAL_W'($urandom_range(3));
			default: return $urandom;
		endcase
	endfunction

	// called at a falling edge; leaves valid high for a following item
	task automatic send_value(input logic [VAL_W-1:0] v);
		while ($urandom_range(99) < src_idle_pct) begin
			value_valid <= 1'b0;
			@(negedge clk);
		end
		value_valid <= 1'b1;
		value       <= v;
		@(posedge clk);
		while (value_stall)
			@(posedge clk);
		fold_value(v);
		@(negedge clk);
	endtask

	// item 0 gives no result, so pad past the latency once the queue is empty
	task automatic wait_drained();
		value_valid <= 1'b0;
		while (running_max_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_log_size(input logic [LOG_W-1:0] v);
		log_size_we    <= 1'b1;
		log_size_wdata <= v;
		@(posedge clk);
		cur_log = v;
		@(negedge clk);
		log_size_we <= 1'b0;
	endtask

	task automatic test_directed();
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		// max values, sum needs bit 32
		write_log_size(LOG_W'(2));
		send_value('1);
		send_value('1);
		send_value('0);
		send_value('1);
		wait_drained();
		// zero setting clamps to a run of two; equal values tie
		write_log_size(LOG_W'(0));
		send_value('0);
		send_value('0);
		send_value(VAL_W'(5));
		send_value(VAL_W'(5));
		wait_drained();
		write_log_size(LOG_W'(1));
		send_value('1);
		send_value(VAL_W'(1));
		wait_drained();
		// oversize setting clamps to LOG_MAX, then lowered past the current index
		write_log_size(LOG_W'(15));
		send_value(VAL_W'(7));
		send_value(VAL_W'(7));
		send_value(VAL_W'(7));
		send_value(VAL_W'(3));
		send_value(VAL_W'(9));
		send_value(VAL_W'(9));
		wait_drained();
		write_log_size(LOG_W'(2));
		send_value(VAL_W'(1));
		wait_drained();
	endtask

	// one long run so the high index bits toggle; ends by lowering the length
	task automatic test_long_run();
		src_idle_pct  = 22;
		snk_stall_pct = 22;
		write_log_size(LOG_W'(LOG_MAX));
		repeat (600)
			send_value(rand_value());
		wait_drained();
		write_log_size(LOG_W'(LOG_MAX - 1));
		send_value(rand_value());
		wait_drained();
	endtask

	task automatic test_random_runs(input int unsigned items, input int unsigned idle_pct,
			input int unsigned stall_pct);
		int unsigned      sent, burst, run_len;
		logic [LOG_W-1:0] lg;
		src_idle_pct  = idle_pct;
		snk_stall_pct = stall_pct;
		sent = 0;
		while (sent < items) begin
			lg = ($urandom_range(9) == 0) ? LOG_W'(0) : LOG_W'($urandom_range(1, 5));
			write_log_size(lg);
			run_len = 1 << ((lg == 0) ? 1 : lg);
			burst = (run_pos < run_len) ? run_len - run_pos : 1;
			// mostly whole runs, sometimes a partial one
			if ($urandom_range(3) == 0)
				burst = $urandom_range(1, burst);
			repeat (burst)
				send_value(rand_value());
			sent += burst;
			wait_drained();
		end
	endtask

	task automatic test_backpressure();
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		write_log_size(LOG_W'(3));
		hold_reqs++;
		repeat (24)
			send_value(rand_value());
		wait_drained();
	endtask

	initial begin
		repeat (7)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_long_run();
		test_random_runs(75, 0, 0);
		test_random_runs(75, 83, 0);
		test_random_runs(75, 0, 83);
		test_random_runs(75, 22, 22);
		test_backpressure();
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
